FILE: design/bdlp_pkg.sv
package bdlp_pkg;

   typedef enum logic [1:0] {
      MODE_SAMPLE  = 2'd0,
      MODE_CONSUME = 2'd1,
      MODE_QUERY   = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE   = 2'd0,
      CSR_LONG_PRESS = 2'd1,
      CSR_LONG_BTN   = 2'd2,
      CSR_NONE       = 2'd3
   } csr_index_type;

   localparam int EVENT_BITS = 4;
   localparam int MS_BITS    = 16;
   localparam int BTN_BITS   = 3;
   localparam int LEVEL_BITS = 8;
   localparam int NOW_BITS   = 32;
   localparam int HOLD_BITS  = 32;

   typedef struct packed {
      logic press;
      logic long_fire;
   } lane_evt_type;

endpackage

FILE: design/bdlp_lane.sv
module bdlp_lane
   import bdlp_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 sample,
   input  logic                 raw,
   input  logic [TIME_BITS-1:0] now,
   input  logic [MS_BITS-1:0]   debounce_ms,
   input  logic [MS_BITS-1:0]   long_press_ms,
   input  logic                 long_en,
   output logic                 pressed,
   output logic                 pressed_next,
   output logic [TIME_BITS-1:0] press_stamp,
   output lane_evt_type         evt
);

   logic                 last_raw_ff, last_raw_in;
   logic                 stable_ff, stable_in;
   logic                 long_done_ff, long_done_in;
   logic [TIME_BITS-1:0] change_stamp_ff, change_stamp_in;
   logic [TIME_BITS-1:0] press_stamp_ff, press_stamp_in;

   logic                 changed;
   logic                 settled;
   logic                 flip;
   logic                 long_fire;
   logic [TIME_BITS-1:0] since_change;
   logic [TIME_BITS-1:0] since_press;

   always_comb begin
      changed      = raw != last_raw_ff;
      since_change = now - change_stamp_ff;
      since_press  = now - press_stamp_ff;
      // a fresh change gives zero elapsed time
      settled      = changed ? (debounce_ms == '0)
                             : (since_change >= TIME_BITS'(debounce_ms));
      flip         = settled && (raw != stable_ff);
      long_fire    = settled && !flip && raw && long_en && !long_done_ff &&
                     (since_press > TIME_BITS'(long_press_ms));

      last_raw_in     = last_raw_ff;
      change_stamp_in = change_stamp_ff;
      stable_in       = stable_ff;
      long_done_in    = long_done_ff;
      press_stamp_in  = press_stamp_ff;
      if (sample) begin
         last_raw_in = raw;
         if (changed) begin
            change_stamp_in = now;
         end
         if (flip) begin
            stable_in    = raw;
            long_done_in = 1'b0;
            if (raw) begin
               press_stamp_in = now;
            end
         end
         if (long_fire) begin
            long_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff     <= 1'b0;
         stable_ff       <= 1'b0;
         long_done_ff    <= 1'b0;
         change_stamp_ff <= '0;
         press_stamp_ff  <= '0;
      end else begin
         last_raw_ff     <= last_raw_in;
         stable_ff       <= stable_in;
         long_done_ff    <= long_done_in;
         change_stamp_ff <= change_stamp_in;
         press_stamp_ff  <= press_stamp_in;
      end
   end

   assign pressed       = stable_ff;
   assign pressed_next  = stable_in;
   assign press_stamp   = press_stamp_ff;
   assign evt.press     = sample && flip && raw;
   assign evt.long_fire = sample && long_fire;

endmodule

FILE: design/bdlp_merge.sv
module bdlp_merge
   import bdlp_pkg::*;
#(
   parameter int BUTTONS = 8
) (
   input  lane_evt_type [BUTTONS-1:0] evts,
   output logic                       fire,
   output logic [EVENT_BITS-1:0]      code
);

   localparam logic [EVENT_BITS-1:0] LongCode = EVENT_BITS'(BUTTONS + 1);

   // higher lane index wins; a lane's long press comes after its press
   always_comb begin
      fire = 1'b0;
      code = '0;
      for (int i = 0; i < BUTTONS; i++) begin
         if (evts[i].long_fire) begin
            fire = 1'b1;
            code = LongCode;
         end else if (evts[i].press) begin
            fire = 1'b1;
            code = EVENT_BITS'(i + 1);
         end
      end
   end

endmodule

FILE: design/button_debounce_long_press_events_top.sv
// channel  dir  handshake          payload
// req      in   req_tvalid/tready  tuser: mode; tdata: levels, now_ms, button_index
// rsp      out  rsp_tvalid/tready  tdata: event_code, hold_ms, pressed_mask
// csr      in   csr_we             csr_index, csr_wdata
// one word per cycle unless a response is blocked: each button lane updates its state in the accept cycle,
// the event merge and the query select finish in that same cycle.
// a response appears in the cycle after its request is accepted, from the output register.
// req_tready is low only while a response waits and rsp_tready is low.
// synchronous reset restores register defaults and clears all button state.
module button_debounce_long_press_events_top
   import bdlp_pkg::*;
#(
   parameter int BUTTONS   = 8,
   parameter int TIME_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,  // mode
   input  logic [47:0]  req_tdata,  // button_levels, now_ms, button_index, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // event_code, hold_ms, pressed_mask, zero pad
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   logic                  accept;
   mode_type              mode;
   logic [LEVEL_BITS-1:0] levels;
   logic [TIME_BITS-1:0]  now;
   logic [BTN_BITS-1:0]   query_idx;

   logic [MS_BITS-1:0]    debounce_ff, debounce_in;
   logic [MS_BITS-1:0]    long_ms_ff, long_ms_in;
   logic [BTN_BITS-1:0]   long_btn_ff, long_btn_in;
   logic [EVENT_BITS-1:0] pending_ff, pending_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EVENT_BITS-1:0] rsp_event_ff, rsp_event_in;
   logic [HOLD_BITS-1:0]  rsp_hold_ff, rsp_hold_in;
   logic [LEVEL_BITS-1:0] rsp_mask_ff, rsp_mask_in;

   logic                  sample;
   logic [BUTTONS-1:0]    pressed;
   logic [BUTTONS-1:0]    pressed_next;
   logic [TIME_BITS-1:0]  press_stamp [BUTTONS];
   lane_evt_type [BUTTONS-1:0] evts;
   logic                  evt_fire;
   logic [EVENT_BITS-1:0] evt_code;
   logic [TIME_BITS-1:0]  hold_t;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign mode       = mode_type'(req_tuser);
   assign levels     = req_tdata[7:0];
   assign now        = TIME_BITS'(req_tdata[39:8]);
   assign query_idx  = req_tdata[42:40];
   assign sample     = accept && (mode == MODE_SAMPLE);

   for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
      logic raw;
      if (g < LEVEL_BITS) begin : g_pin
         assign raw = levels[g];
      end else begin : g_none
         assign raw = 1'b0;
      end
      bdlp_lane #(
         .TIME_BITS(TIME_BITS)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .sample       (sample),
         .raw          (raw),
         .now          (now),
         .debounce_ms  (debounce_ff),
         .long_press_ms(long_ms_ff),
         .long_en      (int'(long_btn_ff) == g),
         .pressed      (pressed[g]),
         .pressed_next (pressed_next[g]),
         .press_stamp  (press_stamp[g]),
         .evt          (evts[g])
      );
   end

   bdlp_merge #(
      .BUTTONS(BUTTONS)
   ) u_merge (
      .evts(evts),
      .fire(evt_fire),
      .code(evt_code)
   );

   always_comb begin
      hold_t = '0;
      for (int i = 0; i < BUTTONS; i++) begin
         if (int'(query_idx) == i && pressed[i]) begin
            hold_t = now - press_stamp[i];
         end
      end
   end

   always_comb begin
      debounce_in = debounce_ff;
      long_ms_in  = long_ms_ff;
      long_btn_in = long_btn_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:   debounce_in = csr_wdata;
            CSR_LONG_PRESS: long_ms_in  = csr_wdata;
            CSR_LONG_BTN:   long_btn_in = csr_wdata[BTN_BITS-1:0];
            default:        ;
         endcase
      end

      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_event_in = rsp_event_ff;
      rsp_hold_in  = rsp_hold_ff;
      rsp_mask_in  = rsp_mask_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = '0;
         rsp_hold_in  = '0;
         case (mode)
            MODE_SAMPLE: begin
               if (evt_fire) begin
                  pending_in = evt_code;
               end
            end
            MODE_CONSUME: begin
               rsp_event_in = pending_ff;
               pending_in   = '0;
            end
            MODE_QUERY: begin
               rsp_hold_in = HOLD_BITS'(hold_t);
            end
            default: ;
         endcase
         rsp_mask_in = '0;
         for (int j = 0; j < LEVEL_BITS; j++) begin
            if (j < BUTTONS) begin
               rsp_mask_in[j] = pressed_next[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= MS_BITS'(25);
         long_ms_ff   <= MS_BITS'(800);
         long_btn_ff  <= BTN_BITS'(4);
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         debounce_ff  <= debounce_in;
         long_ms_ff   <= long_ms_in;
         long_btn_ff  <= long_btn_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_event_ff <= rsp_event_in;
      rsp_hold_ff  <= rsp_hold_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_mask_ff, rsp_hold_ff, rsp_event_ff};

   a_no_take_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while response is blocked");

   a_consume_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == MODE_CONSUME) |=> (pending_ff == '0))
      else $error("event slot not cleared by consume");

   a_hold_only_query: assert property (@(posedge clock) disable iff (reset)
      (accept && mode != MODE_QUERY) |=> (rsp_tvalid && rsp_tdata[35:4] == '0))
      else $error("hold reported outside a query");

   a_event_only_consume: assert property (@(posedge clock) disable iff (reset)
      (accept && mode != MODE_CONSUME) |=> (rsp_tdata[3:0] == '0))
      else $error("event reported outside a consume");

endmodule

FILE: bench/tb.sv
module tb;
   import bdlp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] NO_EVENT        = 4'd0;
   localparam logic [3:0] LONG_PRESS_CODE = 4'd9;
   localparam int         PHASES          = 8;
   localparam int         WORDS_PER_PHASE = 194;
   localparam int         STALL_LIMIT     = 2000;
   localparam int         MAX_REPORTS     = 60;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  levels;
      logic [31:0] now_ms;
      logic [2:0]  btn;
   } button_word_type;

   typedef struct packed {
      logic [3:0]  event_code;
      logic [31:0] hold_ms;
      logic [7:0]  mask;
   } button_report_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   // predictor copy of the block state and registers
   bit [15:0] cfg_debounce = 16'd25;
   bit [15:0] cfg_long_ms  = 16'd800;
   bit [2:0]  cfg_long_btn = 3'd4;
   bit        debounced [8];
   bit        raw_seen [8];
   bit [31:0] changed_at [8];
   bit [31:0] pressed_at [8];
   bit        long_fired [8];
   bit [3:0]  slot_event;

   button_word_type   button_words [$];
   button_report_type awaited_reports [$];
   button_word_type   cur_word;
   button_report_type want, got;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int idle_cycles   = 0;
   int mismatches    = 0;
   int words_sent    = 0;
   int reports_seen  = 0;
   int press_events  = 0;
   int long_events   = 0;
   int hold_reads    = 0;

   bit [31:0] t_now;
   bit [7:0]  lv_now, lv_prev;

   int deb_tab   [PHASES] = '{25, 0, 65535, 3, 1, 10, 0, 65535};
   int lp_tab    [PHASES] = '{800, 0, 65535, 40, 1, 200, 65535, 0};
   int btn_tab   [PHASES] = '{4, 0, 7, 2, 5, 3, 1, 6};
   int send_tab  [PHASES] = '{0, 71, 0, 8, 0, 71, 0, 8};
   int stall_tab [PHASES] = '{0, 0, 71, 8, 0, 0, 71, 8};

   button_debounce_long_press_events_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic button_report_type predict_buttons(input button_word_type w);
      button_report_type rep;
      bit [31:0]         since;
      bit                raw;
      rep = '0;
      case (w.mode)
         MODE_SAMPLE: begin
            for (int i = 0; i < 8; i++) begin
               raw = w.levels[i];
               if (raw != raw_seen[i]) begin
                  changed_at[i] = w.now_ms;
                  raw_seen[i]   = raw;
               end
               since = w.now_ms - changed_at[i];
               if (since >= {16'd0, cfg_debounce}) begin
                  if (raw != debounced[i]) begin
                     debounced[i]  = raw;
                     long_fired[i] = 1'b0;
                     if (raw) begin
                        pressed_at[i] = w.now_ms;
                        slot_event    = 4'(i + 1);
                     end
                  end
                  since = w.now_ms - pressed_at[i];
                  if (raw && !long_fired[i] && i == int'(cfg_long_btn) &&
                      since > {16'd0, cfg_long_ms}) begin
                     long_fired[i] = 1'b1;
                     slot_event    = LONG_PRESS_CODE;
                  end
               end
            end
         end
         MODE_CONSUME: begin
            rep.event_code = slot_event;
            slot_event     = NO_EVENT;
         end
         MODE_QUERY: begin
            if (debounced[w.btn])
               rep.hold_ms = w.now_ms - pressed_at[w.btn];
         end
         default: ;
      endcase
      for (int i = 0; i < 8; i++)
         rep.mask[i] = debounced[i];
      return rep;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_reports.push_back(predict_buttons(cur_word));
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (button_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_word = button_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cur_word.mode;
               req_tdata  <= {5'd0, cur_word.btn, cur_word.now_ms, cur_word.levels};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.event_code = rsp_tdata[3:0];
            got.hold_ms    = rsp_tdata[35:4];
            got.mask       = rsp_tdata[43:36];
            reports_seen++;
            if (awaited_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t unexpected word: expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = awaited_reports.pop_front();
               if (want.event_code inside {[4'd1 : 4'd8]}) press_events++;
               if (want.event_code == LONG_PRESS_CODE) long_events++;
               if (want.hold_ms != 0) hold_reads++;
               if (got.event_code != want.event_code) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t event_code mismatch: expected %0d, actual %0d",
                              $time, want.event_code, got.event_code);
               end
               if (got.hold_ms != want.hold_ms) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t hold_ms mismatch: expected %0d, actual %0d",
                              $time, want.hold_ms, got.hold_ms);
               end
               if (got.mask != want.mask) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t pressed_mask mismatch: expected %h, actual %h",
                              $time, want.mask, got.mask);
               end
            end
         end
      end
   end

   // watchdog on stalled traffic
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (button_words.size() == 0 && awaited_reports.size() == 0 && !req_tvalid))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
            $display("** button_debounce_long_press_events_top: FAILED **");
            $finish;
         end
      end
   end

   function automatic button_word_type mk(mode_type m, logic [7:0] lv, logic [31:0] t,
                                          logic [2:0] b);
      button_word_type w;
      w.mode   = m;
      w.levels = lv;
      w.now_ms = t;
      w.btn    = b;
      return w;
   endfunction

   function automatic bit [31:0] time_step();
      int unsigned pick;
      int unsigned deb, lp;
      pick = $urandom_range(99);
      deb  = cfg_debounce;
      lp   = cfg_long_ms;
      if (pick < 10) return 32'd0;
      if (pick < 50) return $urandom_range(deb / 4 + 2, 0);
      if (pick < 70) return $urandom_range(deb + 1, (deb == 0) ? 0 : deb - 1);
      if (pick < 85) return $urandom_range(lp + 1, (lp == 0) ? 0 : lp - 1);
      if (pick < 90) return $urandom;
      return $urandom_range(3, 1);
   endfunction

   task automatic queue_random(input int count);
      int unsigned pick;
      bit [7:0]    swap;
      bit [31:0]   t_query;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 62) begin
            t_now += time_step();
            pick = $urandom_range(99);
            if (pick < 58) begin
               // hold the levels steady
            end else if (pick < 80) begin
               lv_prev = lv_now;
               lv_now ^= 8'(1) << $urandom_range(7);
            end else if (pick < 88) begin
               swap    = lv_now;
               lv_now  = lv_prev;
               lv_prev = swap;
            end else if (pick < 95) begin
               lv_prev = lv_now;
               lv_now  = 8'($urandom);
            end else begin
               lv_prev = lv_now;
               lv_now  = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            button_words.push_back(mk(MODE_SAMPLE, lv_now, t_now, 3'($urandom_range(7))));
         end else if (pick < 77) begin
            button_words.push_back(mk(MODE_CONSUME, 8'($urandom), $urandom,
                                      3'($urandom_range(7))));
         end else if (pick < 93) begin
            t_query = ($urandom_range(99) < 80) ?
                      t_now + $urandom_range(cfg_long_ms + 3) : $urandom;
            button_words.push_back(mk(MODE_QUERY, 8'($urandom), t_query,
                                      ($urandom_range(99) < 40) ? cfg_long_btn
                                                                : 3'($urandom_range(7))));
         end else begin
            button_words.push_back(mk(MODE_UNUSED, 8'($urandom), $urandom,
                                      3'($urandom_range(7))));
         end
      end
   endtask

   task automatic drain();
      while (button_words.size() != 0 || req_tvalid || awaited_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_reg(input csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_DEBOUNCE:   cfg_debounce = val;
         CSR_LONG_PRESS: cfg_long_ms  = val;
         CSR_LONG_BTN:   cfg_long_btn = val[2:0];
         default: ;
      endcase
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         drain();
         repeat (3) @(posedge clock);
         send_idle_pct = send_tab[p];
         stall_pct     = stall_tab[p];
         set_reg(CSR_DEBOUNCE, 16'(deb_tab[p]));
         set_reg(CSR_LONG_PRESS, 16'(lp_tab[p]));
         set_reg(CSR_LONG_BTN, (p == 5) ? 16'($urandom_range(7)) : 16'(btn_tab[p]));
         set_reg(CSR_NONE, 16'($urandom));
         if (p == 0) begin
            button_words.push_back(mk(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 3'd7));
            button_words.push_back(mk(MODE_CONSUME, 8'h00, 32'd0, 3'd0));
            button_words.push_back(mk(MODE_QUERY, 8'h00, 32'd5, 3'd7));
            button_words.push_back(mk(MODE_SAMPLE, 8'h00, 32'd0, 3'd0));
            button_words.push_back(mk(MODE_SAMPLE, 8'hFF, 32'd10, 3'd0));
            // one short of the debounce time, then exactly on it
            button_words.push_back(mk(MODE_SAMPLE, 8'hFF, 32'd34, 3'd0));
            button_words.push_back(mk(MODE_SAMPLE, 8'hFF, 32'd35, 3'd0));
            button_words.push_back(mk(MODE_CONSUME, 8'h00, 32'd36, 3'd0));
            button_words.push_back(mk(MODE_CONSUME, 8'h00, 32'd37, 3'd0));
            button_words.push_back(mk(MODE_QUERY, 8'h00, 32'd100, 3'd3));
            // hold exactly equal to the long press time, then one past
            button_words.push_back(mk(MODE_SAMPLE, 8'hFF, 32'd835, 3'd0));
            button_words.push_back(mk(MODE_SAMPLE, 8'hFF, 32'd836, 3'd0));
            button_words.push_back(mk(MODE_CONSUME, 8'h00, 32'd840, 3'd0));
            // bounce on the long press button must not refire
            button_words.push_back(mk(MODE_SAMPLE, 8'hEF, 32'd900, 3'd0));
            button_words.push_back(mk(MODE_SAMPLE, 8'hFF, 32'd901, 3'd0));
            button_words.push_back(mk(MODE_SAMPLE, 8'hFF, 32'd2000, 3'd0));
            button_words.push_back(mk(MODE_CONSUME, 8'h00, 32'd2000, 3'd0));
            button_words.push_back(mk(MODE_SAMPLE, 8'h00, 32'd2001, 3'd0));
            button_words.push_back(mk(MODE_SAMPLE, 8'h00, 32'd2026, 3'd0));
            button_words.push_back(mk(MODE_QUERY, 8'h00, 32'd2030, 3'd4));
            button_words.push_back(mk(MODE_UNUSED, 8'h55, 32'h5555_5555, 3'd2));
            // debounce and hold across the time stamp wrap
            button_words.push_back(mk(MODE_SAMPLE, 8'h01, 32'hFFFF_FFF0, 3'd0));
            button_words.push_back(mk(MODE_SAMPLE, 8'h01, 32'h0000_0010, 3'd0));
            button_words.push_back(mk(MODE_QUERY, 8'h00, 32'h0000_0005, 3'd0));
            button_words.push_back(mk(MODE_CONSUME, 8'h00, 32'h0000_0011, 3'd0));
            t_now   = 32'h0000_0010;
            lv_now  = 8'h01;
            lv_prev = 8'h01;
         end
         queue_random(WORDS_PER_PHASE / 2);
         // sender waits here until every response is back
         drain();
         queue_random(WORDS_PER_PHASE - WORDS_PER_PHASE / 2);
      end
      drain();
      repeat (4) @(posedge clock);
      $display("ran %0d request words through %0d register settings, %0d responses checked",
               words_sent, PHASES, reports_seen);
      $display("press events %0d, long presses %0d, nonzero hold reads %0d",
               press_events, long_events, hold_reads);
      if (mismatches == 0) begin
         $display("** button_debounce_long_press_events_top: PASSED **");
      end else begin
         $display("** button_debounce_long_press_events_top: FAILED **");
      end
      $finish;
   end

endmodule
